// ===== src/scsm_pkg.sv =====
// Shared widths, command and register codes, and reset values for the
// constant-speed stepper move block. No dependencies.
`default_nettype none

package scsm_pkg;

    // Field widths
    localparam int CMD_W      = 3;
    localparam int DUR_W      = 16;
    localparam int DELTA_W    = 24;
    localparam int POS_W      = 32;
    localparam int TPM_W      = 20;
    localparam int PERIOD_W   = 32;
    localparam int PROD_W     = DUR_W + TPM_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [CMD_W-1:0] cmd_t;

    // Command codes
    localparam cmd_t CMD_TICK       = 3'd0;
    localparam cmd_t CMD_MOVE       = 3'd1;
    localparam cmd_t CMD_STOP       = 3'd2;
    localparam cmd_t CMD_MOTOR_ON   = 3'd3;
    localparam cmd_t CMD_MOTOR_OFF  = 3'd4;
    localparam cmd_t CMD_MOTOR_TGL  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PERIOD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DUR  = 2'd3;

    // Reset values
    localparam logic [TPM_W-1:0]    RST_TICKS_PER_MS = 20'd80000;
    localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD   = 32'd4000;
    localparam logic [PERIOD_W-1:0] RST_IDLE_PERIOD  = 32'd160000;
    localparam logic [DUR_W-1:0]    RST_DEFAULT_DUR  = 16'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_SAT       = 32'hffff_ffff;

endpackage

`default_nettype wire

// ===== src/stepper_constant_speed_move.sv =====
// Top level of the constant-speed stepper move block: command decode, axis
// state, output register. Depends on scsm_pkg, scsm_mul and scsm_div.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command, duration_ms and
//   step_delta. Each accepted item yields exactly one result item on the
//   output channel (out_valid/out_ready): step, direction and enable levels,
//   busy flag, position and the ignored-move flag.
//   Tick, stop, motor and ignored-move items are taken one per cycle while
//   the receiver keeps up; the result is registered and appears in the
//   output register in the cycle after acceptance. A move that starts a run
//   also returns its result in the cycle after acceptance, but the input
//   then stays closed through a serial multiply and a serial divide (one
//   bit per cycle), each followed by its done strobe, then the load step.
//   A zero-step move closes the input for the load step only.
//   The output register holds one result; a new item is accepted while the
//   receiver takes the waiting one, and is held off while it stalls.
//   Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once.
//   Reset clears the axis state, turns the motor off and restores the
//   default configuration values.
`default_nettype none

module stepper_constant_speed_move
    import scsm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // input channel
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic [DUR_W-1:0]         duration_ms,
    input  wire logic signed [DELTA_W-1:0] step_delta,
    // output channel
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          step_level,
    output logic                          dir_level,
    output logic                          motor_enable,
    output logic                          busy_res,
    output logic signed [POS_W-1:0]       position,
    output logic                          move_ignored,
    // configuration
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_LOAD
    } state_t;

    // configuration
    logic [TPM_W-1:0]    ticks_per_ms_reg;
    logic [PERIOD_W-1:0] min_period_reg;
    logic [PERIOD_W-1:0] idle_period_reg;
    logic [DUR_W-1:0]    default_dur_reg;

    // axis state
    state_t              state_reg, state_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic [POS_W-1:0]    target_reg, target_next;
    logic [PERIOD_W-1:0] half_period_reg, half_period_next;
    logic [PERIOD_W-1:0] countdown_reg, countdown_next;
    logic                pulse_reg, pulse_next;
    logic                running_reg, running_next;
    logic                motor_reg, motor_next;
    logic                dir_reg, dir_next;
    logic [DELTA_W-1:0]  mag_reg, mag_next;
    logic                zero_steps_reg, zero_steps_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic                ignored_reg, ignored_next;
    logic                step_out_reg, dir_out_reg, motor_out_reg, busy_out_reg;
    logic [POS_W-1:0]    pos_out_reg;

    // serial arithmetic
    logic                mul_start, mul_done;
    logic                div_start, div_done;
    logic [PROD_W-1:0]   product, quotient;

    // decode helpers
    logic                in_fire;
    logic [DELTA_W-1:0]  delta_u;
    logic [POS_W-1:0]    delta_ext;
    logic [DELTA_W-1:0]  mag;
    logic [DUR_W-1:0]    dur_sel;
    logic [PROD_W-1:0]   period_wide;
    logic [PERIOD_W-1:0] period_sat;
    logic [PERIOD_W-1:0] period_clamp;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    assign delta_u   = step_delta;
    assign delta_ext = {{(POS_W-DELTA_W){delta_u[DELTA_W-1]}}, delta_u};
    assign mag       = delta_u[DELTA_W-1] ? (DELTA_W'(0) - delta_u) : delta_u;
    assign dur_sel   = (duration_ms == '0) ? default_dur_reg : duration_ms;

    // Period from quotient minus one, or the idle period for a zero-step move: saturate, clamp (halved in ST_LOAD)
    always_comb
    begin
        if (zero_steps_reg)
        begin
            period_wide = PROD_W'(idle_period_reg);
        end
        else if (quotient == '0)
        begin
            period_wide = '0;
        end
        else
        begin
            period_wide = quotient - PROD_W'(1);
        end
        if (period_wide[PROD_W-1:PERIOD_W] != '0)
        begin
            period_sat = PERIOD_SAT;
        end
        else
        begin
            period_sat = period_wide[PERIOD_W-1:0];
        end
        period_clamp = (period_sat < min_period_reg) ? min_period_reg : period_sat;
    end

    // Command decode and sequencing
    always_comb
    begin
        state_next       = state_reg;
        position_next    = position_reg;
        target_next      = target_reg;
        half_period_next = half_period_reg;
        countdown_next   = countdown_reg;
        pulse_next       = pulse_reg;
        running_next     = running_reg;
        motor_next       = motor_reg;
        dir_next         = dir_reg;
        mag_next         = mag_reg;
        zero_steps_next  = zero_steps_reg;
        ignored_next     = 1'b0;
        mul_start        = 1'b0;
        div_start        = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    case (command)
                        CMD_TICK:
                        begin
                            if (running_reg)
                            begin
                                if (countdown_reg <= PERIOD_W'(1))
                                begin
                                    countdown_next = half_period_reg;
                                    if (pulse_reg)
                                    begin
                                        pulse_next = 1'b0;
                                        if (position_reg == target_reg)
                                        begin
                                            running_next = 1'b0;
                                        end
                                    end
                                    else if (position_reg != target_reg)
                                    begin
                                        pulse_next = 1'b1;
                                        if ($signed(position_reg) > $signed(target_reg))
                                        begin
                                            position_next = position_reg - POS_W'(1);
                                        end
                                        else
                                        begin
                                            position_next = position_reg + POS_W'(1);
                                        end
                                    end
                                    else
                                    begin
                                        running_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    countdown_next = countdown_reg - PERIOD_W'(1);
                                end
                            end
                        end
                        CMD_MOVE:
                        begin
                            if (running_reg)
                            begin
                                ignored_next = 1'b1;
                            end
                            else
                            begin
                                motor_next      = 1'b1;
                                pulse_next      = 1'b0;
                                target_next     = target_reg + delta_ext;
                                dir_next        = $signed(target_reg + delta_ext) >
                                                  $signed(position_reg);
                                running_next    = 1'b1;
                                mag_next        = mag;
                                zero_steps_next = (mag == '0);
                                if (mag == '0)
                                begin
                                    state_next = ST_LOAD;
                                end
                                else
                                begin
                                    mul_start  = 1'b1;
                                    state_next = ST_MUL;
                                end
                            end
                        end
                        CMD_STOP:
                        begin
                            running_next   = 1'b0;
                            countdown_next = '0;
                            target_next    = position_reg;
                            pulse_next     = 1'b0;
                        end
                        CMD_MOTOR_ON:  motor_next = 1'b1;
                        CMD_MOTOR_OFF: motor_next = 1'b0;
                        CMD_MOTOR_TGL: motor_next = !motor_reg;
                        default: ;
                    endcase
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                half_period_next = {1'b0, period_clamp[PERIOD_W-1:1]};
                countdown_next   = {1'b0, period_clamp[PERIOD_W-1:1]};
                state_next       = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            position_reg    <= '0;
            target_reg      <= '0;
            half_period_reg <= '0;
            countdown_reg   <= '0;
            pulse_reg       <= 1'b0;
            running_reg     <= 1'b0;
            motor_reg       <= 1'b0;
            dir_reg         <= 1'b0;
            mag_reg         <= '0;
            zero_steps_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            ignored_reg     <= 1'b0;
            step_out_reg    <= 1'b0;
            dir_out_reg     <= 1'b0;
            motor_out_reg   <= 1'b0;
            busy_out_reg    <= 1'b0;
            pos_out_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            position_reg    <= position_next;
            target_reg      <= target_next;
            half_period_reg <= half_period_next;
            countdown_reg   <= countdown_next;
            pulse_reg       <= pulse_next;
            running_reg     <= running_next;
            motor_reg       <= motor_next;
            dir_reg         <= dir_next;
            mag_reg         <= mag_next;
            zero_steps_reg  <= zero_steps_next;
            out_valid_reg   <= out_valid_next;
            if (in_fire)
            begin
                ignored_reg   <= ignored_next;
                step_out_reg  <= pulse_next;
                dir_out_reg   <= dir_next;
                motor_out_reg <= motor_next;
                busy_out_reg  <= running_next;
                pos_out_reg   <= position_next;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_ms_reg <= RST_TICKS_PER_MS;
            min_period_reg   <= RST_MIN_PERIOD;
            idle_period_reg  <= RST_IDLE_PERIOD;
            default_dur_reg  <= RST_DEFAULT_DUR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TICKS_PER_MS: ticks_per_ms_reg <= cfg_data[TPM_W-1:0];
                REG_MIN_PERIOD:   min_period_reg   <= cfg_data[PERIOD_W-1:0];
                REG_IDLE_PERIOD:  idle_period_reg  <= cfg_data[PERIOD_W-1:0];
                REG_DEFAULT_DUR:  default_dur_reg  <= cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // Serial period arithmetic
    scsm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (ticks_per_ms_reg),
        .mplier  (dur_sel),
        .done    (mul_done),
        .product (product)
    );

    scsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (mag_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_valid    = out_valid_reg;
    assign step_level   = step_out_reg;
    assign dir_level    = dir_out_reg;
    assign motor_enable = motor_out_reg;
    assign busy_res     = busy_out_reg;
    assign position     = pos_out_reg;
    assign move_ignored = ignored_reg;

    // A raised step pulse only exists while the timer runs
    a_pulse_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_reg |-> running_reg)
        else $error("step pulse high with timer stopped");

    // Stop leaves the target at the position and the timer stopped
    a_stop_settles: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && command == CMD_STOP) |=>
            (target_reg == position_reg) && !running_reg && !pulse_reg)
        else $error("stop did not settle axis");

    // A tick while idle does not move the axis
    a_idle_tick_still: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && command == CMD_TICK && !running_reg) |=> $stable(position_reg))
        else $error("position moved on idle tick");

    // An ignored move is only reported while busy
    a_ignored_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ignored_reg) |-> busy_out_reg)
        else $error("ignored move reported while not busy");

    // The period computation never runs with the timer stopped
    a_compute_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> running_reg)
        else $error("period computation without running timer");

endmodule

`default_nettype wire

// ===== src/scsm_mul.sv =====
// Serial shift-add multiplier: one multiplier bit per cycle, MSB first.
// Depends on scsm_pkg.
`default_nettype none

module scsm_mul
    import scsm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [TPM_W-1:0]  mcand,
    input  wire logic [DUR_W-1:0]  mplier,
    output logic                   done,
    output logic [PROD_W-1:0]      product
);

    localparam int CNT_W = $clog2(DUR_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DUR_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [DUR_W-1:0]   mplier_reg;
    logic [TPM_W-1:0]   mcand_reg;
    logic [PROD_W-1:0]  acc_next;

    // Shift accumulator, add multiplicand when the current bit is set
    always_comb
    begin
        acc_next = {acc_reg[PROD_W-2:0], 1'b0};
        if (mplier_reg[DUR_W-1])
        begin
            acc_next = acc_next + PROD_W'(mcand_reg);
        end
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mplier_reg <= mplier;
            mcand_reg  <= mcand;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mplier_reg <= {mplier_reg[DUR_W-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== src/scsm_div.sv =====
// Restoring divider: one quotient bit per cycle.
// Depends on scsm_pkg.
`default_nettype none

module scsm_div
    import scsm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [PROD_W-1:0]  dividend,
    input  wire logic [DELTA_W-1:0] divisor,
    output logic                    done,
    output logic [PROD_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DELTA_W-1:0]  rem_reg;
    logic [PROD_W-1:0]   quo_reg;
    logic [DELTA_W-1:0]  dsr_reg;
    logic [DELTA_W:0]    shifted;
    logic [DELTA_W+1:0]  diff;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[PROD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: remainder stays below the divisor, so it fits DELTA_W bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DELTA_W+1])
            begin
                rem_reg <= diff[DELTA_W-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DELTA_W-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
